// File: rtl/core/lppd_pkg.sv
`default_nettype none
package lppd_pkg;

   typedef enum logic [1:0] {
      FRAME_HUNT   = 2'd0,
      FRAME_HDR    = 2'd1,
      FRAME_PACKET = 2'd2
   } frame_type;

   typedef enum logic [2:0] {
      SEQ_IDLE   = 3'd0,
      SEQ_DIV    = 3'd1,
      SEQ_CORDIC = 3'd2,
      SEQ_SUM    = 3'd3,
      SEQ_WRAP   = 3'd4,
      SEQ_OUT    = 3'd5
   } seq_type;

   localparam logic [7:0]  HDR_BYTE0    = 8'hAA;
   localparam logic [7:0]  HDR_BYTE1    = 8'h55;
   localparam int          CORDIC_STEPS = 18;
   localparam int          CORDIC_W     = 48;
   localparam logic [18:0] FULL_TURN    = 19'd368640;
   localparam logic [18:0] HALF_TURN    = 19'd184320;
   localparam logic [15:0] ANGLE_WRAP   = 16'd23040;
   localparam logic [15:0] DEFAULT_MIN_DIST = 16'd40;

   function automatic logic [21:0] atan_entry(input logic [4:0] k);
      logic [21:0] v;
      begin
         case (k)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            default: v = 22'd0;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/lppd_frame.sv
`default_nettype none
// Byte framer: header hunt, packet header fields, sample assembly.
module lppd_frame
   import lppd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_en,
   input  wire logic [7:0]  byte_in,
   output logic             sample_en,
   output logic [15:0]      sample_dist,
   output logic [7:0]       sample_idx,
   output logic [7:0]       count,
   output logic [14:0]      start_ang,
   output logic [14:0]      end_ang
);
   frame_type   state_ff, state_in;
   logic [9:0]  pos_ff, pos_in;
   logic [7:0]  count_ff, count_in, low_ff, low_in;
   logic [14:0] start_ff, start_in, end_ff, end_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  idx_ff, idx_in;
   logic [10:0] last_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRAME_HUNT;
         pos_ff   <= '0;
         count_ff <= '0;
         start_ff <= '0;
         end_ff   <= '0;
         low_ff   <= '0;
         phase_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         low_ff   <= low_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   assign last_pos = 11'd7 + 11'(count_ff) + {2'b0, count_ff, 1'b0};

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      low_in      = low_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      sample_en   = 1'b0;
      if (byte_en) begin
         case (state_ff)
            FRAME_HDR: begin
               if (byte_in == HDR_BYTE1) begin
                  state_in = FRAME_PACKET;
                  pos_in   = 10'd2;
               end else if (byte_in != HDR_BYTE0) begin
                  state_in = FRAME_HUNT;
               end
            end
            FRAME_PACKET: begin
               pos_in = pos_ff + 10'd1;
               if ({1'b0, pos_ff} >= last_pos) state_in = FRAME_HUNT;
               case (pos_ff)
                  10'd3: count_in = byte_in;
                  10'd4: start_in = {start_ff[14:7], byte_in[7:1]};
                  10'd5: start_in = {byte_in, start_ff[6:0]};
                  10'd6: end_in = {end_ff[14:7], byte_in[7:1]};
                  10'd7: begin
                     end_in   = {byte_in, end_ff[6:0]};
                     phase_in = 2'd0;
                     idx_in   = 8'd0;
                  end
                  default: begin
                     if (pos_ff >= 10'd8) begin
                        case (phase_ff)
                           2'd0: begin
                              low_in   = byte_in;
                              phase_in = 2'd1;
                           end
                           2'd1: begin
                              phase_in  = 2'd2;
                              sample_en = (idx_ff < count_ff);
                           end
                           default: begin
                              phase_in = 2'd0;
                              idx_in   = idx_ff + 8'd1;
                           end
                        endcase
                     end
                  end
               endcase
            end
            default: state_in = (byte_in == HDR_BYTE0) ? FRAME_HDR : FRAME_HUNT;
         endcase
      end
   end

   assign sample_dist = {byte_in, low_ff};
   assign sample_idx  = idx_ff;
   assign count       = count_ff;
   assign start_ang   = start_ff;
   assign end_ang     = end_ff;
endmodule
`default_nettype wire

// File: rtl/core/lppd_calc.sv
`default_nettype none
// Point arithmetic: restoring divider, CORDIC vectoring, rounding and wrap,
// all sequenced one step a cycle; a finished point is held until it is taken.
module lppd_calc
   import lppd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        take,
   input  wire logic [15:0] dist_raw,
   input  wire logic [7:0]  idx,
   input  wire logic [7:0]  count,
   input  wire logic [14:0] start_ang,
   input  wire logic [14:0] end_ang,
   output logic             done,
   output logic [18:0]      angle
);
   seq_type state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   // divider: |numerator| + den/2 up to 32767*16*254 + 127 < 2^27
   logic [26:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [27:0] z_ff, z_in;
   logic signed [27:0] acc_ff, acc_in;
   logic [18:0] ang_ff, ang_in;

   logic signed [16:0] diff_s, diff_w;
   logic signed [27:0] num_s;
   logic [26:0] num_mag;
   logic [7:0]  den;
   logic [8:0]  rem_sh;
   logic signed [27:0] interp;
   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [27:0] zsum;
   logic signed [27:0] zr;
   logic [21:0] at;

   assign diff_s  = $signed({2'b0, end_ang}) - $signed({2'b0, start_ang});
   // add one turn once; the difference may stay negative
   assign diff_w  = (diff_s < 0) ? diff_s + $signed(17'(ANGLE_WRAP)) : diff_s;
   assign num_s   = 28'(diff_w) * $signed({16'b0, idx, 4'b0});
   assign num_mag = (num_s < 0) ? 27'(-num_s) : 27'(num_s);
   assign den     = count - 8'd1;
   assign interp  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   function automatic logic signed [CORDIC_W-1:0] shr_t(
      input logic signed [CORDIC_W-1:0] v, input logic [4:0] s);
      logic [CORDIC_W-1:0] m;
      begin
         m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
         m = m >> s;
         return v[CORDIC_W-1] ? -$signed(m) : $signed(m);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      acc_ff  <= acc_in;
      ang_ff  <= ang_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      acc_in   = acc_ff;
      ang_in   = ang_ff;
      done     = 1'b0;
      rem_sh   = {rem_ff, quo_ff[26]};
      xs       = shr_t(x_ff, step_ff);
      ys       = shr_t(y_ff, step_ff);
      at       = atan_entry(step_ff);
      zsum     = z_ff + 28'sd32;
      zr       = (z_ff >= 0) ? (zsum >>> 6) : -((-z_ff + 28'sd32) >>> 6);
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               // magnitude plus half the divisor rounds ties away from zero
               quo_in   = num_mag + 27'(den[7:1]);
               rem_in   = '0;
               neg_in   = (num_s < 0);
               zero_in  = (dist_raw == 16'd0);
               step_in  = '0;
               acc_in   = $signed(28'({13'b0, start_ang} << 4));
               x_in     = $signed(CORDIC_W'(64'd7765 * dist_raw)) <<< 16;
               y_in     = ($signed(CORDIC_W'(32'd677108))
                           - $signed(CORDIC_W'(32'd1090 * dist_raw))) <<< 16;
               z_in     = '0;
               state_in = (count > 8'd1) ? SEQ_DIV : SEQ_CORDIC;
            end
         end
         SEQ_DIV: begin
            // restoring division by den, one quotient bit a cycle
            if (rem_sh >= {1'b0, den}) begin
               rem_in = 8'(rem_sh - {1'b0, den});
               quo_in = {quo_ff[25:0], 1'b1};
            end else begin
               rem_in = rem_sh[7:0];
               quo_in = {quo_ff[25:0], 1'b0};
            end
            if (step_ff == 5'd26) begin
               state_in = SEQ_CORDIC;
               step_in  = '0;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         SEQ_CORDIC: begin
            if (zero_ff) begin
               state_in = SEQ_SUM;
            end else begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + $signed({6'b0, at});
               end else begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - $signed({6'b0, at});
               end
               step_in = step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) state_in = SEQ_SUM;
            end
         end
         SEQ_SUM: begin
            acc_in = acc_ff + zr + ((count > 8'd1) ? interp : 28'sd0);
            state_in = SEQ_WRAP;
         end
         SEQ_WRAP: begin
            if (acc_ff < 0) acc_in = acc_ff + $signed({9'b0, FULL_TURN});
            else if (acc_ff >= $signed({9'b0, FULL_TURN}))
               acc_in = acc_ff - $signed({9'b0, FULL_TURN});
            else begin
               ang_in   = 19'(acc_ff);
               state_in = SEQ_OUT;
            end
         end
         SEQ_OUT: begin
            // hold the point until the output register takes it
            done = 1'b1;
            if (take) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign angle = ang_ff;
endmodule
`default_nettype wire

// File: rtl/core/lidar_packet_point_decoder.sv
`default_nettype none
// Lidar packet point decoder.
// Channels: req_ carries one serial byte per item (req_valid/req_ready);
// rsp_ carries one decoded point per item (rsp_valid/rsp_ready);
// csr_ writes the minimum raw distance register (reset value 40), always ready.
// Header, count, angle and low distance bytes are taken at one per cycle while no point is busy.
// A sample's high distance byte above the threshold starts the point
// arithmetic: one-bit-a-cycle rounding division for the angle
// interpolation (skipped when the packet holds one sample), CORDIC
// iterations for the triangulation correction, a sum, wrap and a hand-over
// to the output register. The next byte is taken at the earliest in the
// same cycle as the point becomes valid, and req_ready is low until then.
// The finished point waits in the output register and bytes keep flowing
// while it waits; a later point finishes its arithmetic and is then held in
// the sequencer, with req_ready low, until the output register is taken.
// Reset (synchronous, active high) returns to the header hunt and clears
// revolution tracking. A stalled receiver holds the output register and any later finished point.
module lidar_packet_point_decoder
   import lppd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_distance_raw,
   output logic [18:0]      rsp_angle,
   output logic [7:0]       rsp_sample_index,
   output logic             rsp_new_revolution,
   output logic             rsp_after_full_revolution,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_min_distance_raw
);
   logic [15:0] min_ff;
   logic        busy_ff, busy_in;
   logic        byte_en, sample_en, point_go, done, load;
   logic [15:0] sdist, dist_ff;
   logic [7:0]  sidx, idx_ff, cnt;
   logic [14:0] sa, ea;
   logic [18:0] ang, prev_ff;
   logic        seen_ff, ov_ff;
   logic        newrev;

   // hold off bytes while a point is computed or waits in the sequencer
   assign req_ready = !busy_ff;
   assign byte_en   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   lppd_frame u_frame (
      .clock, .reset, .byte_en, .byte_in(req_data_byte),
      .sample_en, .sample_dist(sdist), .sample_idx(sidx), .count(cnt),
      .start_ang(sa), .end_ang(ea)
   );

   assign point_go = sample_en && (sdist > min_ff);

   // move a finished point into the output register once it is free
   assign load = done && (!ov_ff || rsp_ready);

   lppd_calc u_calc (
      .clock, .reset, .start(point_go), .take(load), .dist_raw(sdist), .idx(sidx),
      .count(cnt), .start_ang(sa), .end_ang(ea), .done, .angle(ang)
   );

   assign newrev = ({1'b0, ang} + {1'b0, HALF_TURN}) < {1'b0, prev_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= DEFAULT_MIN_DIST;
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
         seen_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         if (csr_valid) min_ff <= csr_min_distance_raw;
         busy_ff <= busy_in;
         if (load) begin
            ov_ff   <= 1'b1;
            prev_ff <= ang;
            if (newrev) seen_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
      if (point_go) begin
         dist_ff <= sdist;
         idx_ff  <= sidx;
      end
      if (load) begin
         rsp_distance_raw          <= dist_ff;
         rsp_angle                 <= ang;
         rsp_sample_index          <= idx_ff;
         rsp_new_revolution        <= newrev;
         rsp_after_full_revolution <= newrev && seen_ff;
      end
   end

   assign busy_in   = point_go ? 1'b1 : (load ? 1'b0 : busy_ff);
   assign rsp_valid = ov_ff;

   // the sequencer never finishes while idle
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("point finished while idle");
   // no byte taken while a point is in flight
   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !byte_en) else $error("byte taken while busy");
   // angle always wrapped
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle < FULL_TURN) else $error("angle not wrapped");
endmodule
`default_nettype wire

// File: test/lidar_packet_point_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module lidar_packet_point_checker
   import lppd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_distance_raw,
   input  wire logic [18:0] rsp_angle,
   input  wire logic [7:0]  rsp_sample_index,
   input  wire logic        rsp_new_revolution,
   input  wire logic        rsp_after_full_revolution,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [15:0] csr_min_distance_raw,
   output int               mismatch_count,
   output int               points_pending,
   output int               points_seen
);

   typedef struct packed {
      logic [15:0] distance_raw;
      logic [18:0] angle;
      logic [7:0]  sample_index;
      logic        new_revolution;
      logic        after_full_revolution;
   } point_type;

   point_type   expected_points[$];
   logic [15:0] min_dist;
   frame_type   frame;
   logic [9:0]  byte_pos;
   logic [7:0]  count;
   logic [14:0] start_ang, end_ang;
   logic [7:0]  dist_lo;
   logic [18:0] prev_ang;
   logic        rev_seen;

   function automatic longint trunc_shift(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint triangulation_offset(logic [15:0] d);
      longint x, y, z, xs, ys;
      z = 0;
      if (d == 0) return 0;
      x = 64'sd7765 * d * 65536;
      y = (64'sd677108 - 64'sd1090 * d) * 65536;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         xs = trunc_shift(x, k);
         ys = trunc_shift(y, k);
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + longint'(atan_entry(k[4:0]));
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(atan_entry(k[4:0]));
         end
      end
      return round_div(z, 64);
   endfunction

   // Advance the framer by one byte; queue a point where one is due.
   task automatic decode_byte(logic [7:0] b);
      logic [9:0]  pos;
      int          k, idx;
      logic [15:0] sample_dist;
      longint      diff, ang;
      point_type   p;
      if (frame == FRAME_HDR) begin
         if (b == HDR_BYTE1) begin
            frame = FRAME_PACKET; byte_pos = 2;
         end else if (b != HDR_BYTE0) frame = FRAME_HUNT;
         return;
      end
      if (frame != FRAME_PACKET) begin
         frame = (b == HDR_BYTE0) ? FRAME_HDR : FRAME_HUNT;
         return;
      end
      pos = byte_pos;
      byte_pos = pos + 1;
      if (int'(pos) >= 7 + 3 * int'(count)) frame = FRAME_HUNT;
      case (pos)
         2: return;
         3: begin count = b; return; end
         4: begin start_ang[6:0] = b[7:1]; return; end
         5: begin start_ang[14:7] = b; return; end
         6: begin end_ang[6:0] = b[7:1]; return; end
         7: begin end_ang[14:7] = b; return; end
         default: ;
      endcase
      if (pos < 8) return;
      k = int'(pos) - 8;
      idx = k / 3;
      if (k % 3 == 0) begin
         dist_lo = b; return;
      end
      if (k % 3 == 2 || idx >= int'(count)) return;
      sample_dist = {b, dist_lo};
      if (sample_dist <= min_dist) return;
      ang = longint'(start_ang) * 16;
      if (count > 1) begin
         diff = longint'(end_ang) - longint'(start_ang);
         if (diff < 0) diff += 23040;
         ang += round_div(diff * 16 * idx, longint'(count) - 1);
      end
      ang += triangulation_offset(sample_dist);
      ang = ang % 368640;
      if (ang < 0) ang += 368640;
      p.distance_raw = sample_dist;
      p.angle = ang[18:0];
      p.sample_index = idx[7:0];
      p.new_revolution = (longint'(ang) + 184320 < longint'(prev_ang));
      p.after_full_revolution = p.new_revolution && rev_seen;
      if (p.new_revolution) rev_seen = 1;
      prev_ang = p.angle;
      expected_points.insert(expected_points.size(), p);
   endtask

   always @(posedge clock) begin
      point_type got, want;
      if (reset) begin
         min_dist = DEFAULT_MIN_DIST; frame = FRAME_HUNT; byte_pos = 0;
         count = 0; start_ang = 0; end_ang = 0; dist_lo = 0;
         prev_ang = 0; rev_seen = 0;
         expected_points.delete();
         mismatch_count = 0; points_seen = 0;
      end else begin
         if (csr_valid && csr_ready) min_dist = csr_min_distance_raw;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_distance_raw, rsp_angle, rsp_sample_index,
                    rsp_new_revolution, rsp_after_full_revolution};
            points_seen++;
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected point %p", got);
            end else begin
               want = expected_points.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("point mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_data_byte);
      end
      points_pending = expected_points.size();
   end

endmodule
`default_nettype wire

// File: test/lidar_packet_point_decoder_test.sv
`timescale 1ns / 100ps
`default_nettype none
module lidar_packet_point_decoder_test;
   import lppd_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_distance_raw;
   logic [18:0] rsp_angle;
   logic [7:0]  rsp_sample_index;
   logic        rsp_new_revolution, rsp_after_full_revolution;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_min_distance_raw = 0;
   int          mismatch_count, points_pending, points_seen;
   int          cycle_count = 0;
   int          bytes_sent = 0;
   bit          receiver_busy = 1;
   logic [7:0]  stream[$];

   always #5 clock = ~clock;

   lidar_packet_point_decoder uut (.*);

   lidar_packet_point_checker checker_i (.*);

   // Give up long after the slowest correct run would have ended.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("lidar_packet_point_decoder_test failed");
         $finish;
      end
   end

   // Receiver: stall at random, mostly briefly, sometimes for long; one
   // phase runs with ready held high throughout.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
         if (!receiver_busy) n = 0;
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Send one byte: hold valid and data until accepted, sometimes after a random gap when gaps is set.
   task automatic send_byte(logic [7:0] b, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic flush_stream(bit gaps);
      while (stream.size() > 0) send_byte(stream.pop_front(), gaps);
      req_valid <= 1'b0;
   endtask

   task automatic add_byte(logic [7:0] b);
      stream.insert(stream.size(), b);
   endtask

   // Queue one packet; angles are raw 16-bit words, distances per sample.
   task automatic queue_packet(int n, logic [15:0] a0, logic [15:0] a1,
                               int dist_mode, logic [7:0] ptype);
      logic [15:0] d;
      add_byte(HDR_BYTE0);
      add_byte(HDR_BYTE1);
      add_byte(ptype);
      add_byte(n[7:0]);
      add_byte(a0[7:0]); add_byte(a0[15:8]);
      add_byte(a1[7:0]); add_byte(a1[15:8]);
      for (int i = 0; i < n; i++) begin
         case (dist_mode)
            0: d = 16'($urandom);
            1: d = 16'($urandom_range(0, 4000));
            2: d = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
            default: d = 16'($urandom_range(30, 50));
         endcase
         add_byte(d[7:0]); add_byte(d[15:8]);
         add_byte(8'($urandom));
      end
   endtask

   // Write the threshold with the block idle: drain results, let the block settle.
   task automatic write_threshold(logic [15:0] v);
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_valid <= 1'b1;
      csr_min_distance_raw <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int kind;
      logic [15:0] thresholds[4];
      thresholds = '{16'd0, 16'd40, 16'd1000, 16'hFFFF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: header resync, broken header, empty packet, full-scale values.
      stream = {8'h00, HDR_BYTE0, HDR_BYTE0, HDR_BYTE1, 8'h00, 8'd0, 8'h00, 8'h00,
                8'h10, 8'h20, HDR_BYTE0, 8'h12};
      flush_stream(0);
      queue_packet(1, 16'hFFFF, 16'h0000, 2, 8'hFF);
      queue_packet(2, 16'h0000, 16'hFFFF, 2, 8'h00);
      flush_stream(0);
      write_threshold(16'd0);
      queue_packet(3, 16'hA001, 16'h1000, 2, 8'h5A);
      flush_stream(1);

      // Random phases: mostly well-formed packets, some noise and cut-off packets.
      for (int phase = 0; phase < 8; phase++) begin
         write_threshold(phase == 7 ? 16'($urandom) : thresholds[phase % 4]);
         receiver_busy = (phase != 3);
         while (bytes_sent < 140 * (phase + 1)) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               queue_packet(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 8),
                            16'($urandom), 16'($urandom), $urandom_range(0, 3),
                            8'($urandom));
            end else if (kind == 7) begin
               repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
            end else begin
               queue_packet($urandom_range(2, 6), 16'($urandom), 16'($urandom), 1,
                            8'($urandom));
               repeat ($urandom_range(1, 10)) void'(stream.pop_back());
            end
            flush_stream(phase != 5);
         end
      end

      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d bytes over several threshold settings; checked %0d points.",
               bytes_sent, points_seen);
      if (mismatch_count == 0)
         $display("lidar_packet_point_decoder_test passed");
      else
         $display("lidar_packet_point_decoder_test failed");
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/lppd_pkg.sv
rtl/core/lppd_frame.sv
rtl/core/lppd_calc.sv
rtl/core/lidar_packet_point_decoder.sv
test/lidar_packet_point_checker.sv
test/lidar_packet_point_decoder_test.sv
